FILE: sv/cltl_pkg.sv
package cltl_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int LENGTH_BITS_DEFAULT   = 16;

    localparam int MAX_RESULTS  = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] KIND_NAME   = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_OP     = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] start;
        logic [15:0] length;
        logic [23:0] line;
    } token_t;

    typedef struct packed {
        logic [1:0]                   count;
        token_t [MAX_RESULTS-1:0]     item;
    } push_t;

endpackage

FILE: sv/cltl_byte_if.sv
interface cltl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

FILE: sv/cltl_token_if.sv
interface cltl_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [23:0] start_position;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_position,
                    output token_length, output line_number, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input start_position,
                  input token_length, input line_number, input last_of_run,
                  output ready);
endinterface

FILE: sv/cltl_core.sv
module cltl_core
    import cltl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_byte,
    output push_t      push
);

    localparam int PW  = POSITION_BITS;
    localparam int LW  = LENGTH_BITS;
    localparam int PWX = (PW > 24) ? PW : 24;
    localparam int LWX = (LW > 16) ? LW : 16;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SLASH  = 5'd1;
    localparam logic [4:0] S_LINE   = 5'd2;
    localparam logic [4:0] S_BLOCK  = 5'd3;
    localparam logic [4:0] S_BSTAR  = 5'd4;
    localparam logic [4:0] S_NAME   = 5'd5;
    localparam logic [4:0] S_NUMBER = 5'd6;
    localparam logic [4:0] S_STRING = 5'd7;
    localparam logic [4:0] S_DOT    = 5'd8;
    localparam logic [4:0] S_DOTDOT = 5'd9;
    localparam logic [4:0] S_OP1    = 5'd10;
    localparam logic [4:0] S_ARROW  = 5'd11;
    localparam logic [4:0] S_SHIFT  = 5'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    logic [4:0]    state_reg, state_next;
    logic [7:0]    prev_reg, prev_next;
    logic [PW-1:0] tstart_reg, tstart_next;
    logic [PW-1:0] tline_reg, tline_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] line_reg, line_next;
    logic [LW-1:0] len_reg, len_next;

    logic [4:0]    st;
    logic [7:0]    pv;
    logic [PW-1:0] ts;
    logic [PW-1:0] tl;
    logic [LW-1:0] ln;
    logic          go;
    logic          ended;
    logic [1:0]    n;
    token_t [MAX_RESULTS-1:0] items;
    logic [7:0]    c;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] ch);
        return is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    endfunction

    function automatic logic pairs_self(input logic [7:0] ch);
        return (ch == 8'h23) || (ch == 8'h3A) || (ch == 8'h26) || (ch == 8'h7C) ||
               (ch == CH_PLUS) || (ch == CH_MINUS);
    endfunction

    function automatic logic pairs_eq(input logic [7:0] ch);
        return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == 8'h25) ||
               (ch == 8'h5E) || (ch == 8'h7C) || (ch == 8'h26) || (ch == 8'h21) ||
               (ch == CH_LT) || (ch == CH_GT) || (ch == CH_EQ);
    endfunction

    function automatic logic [PW-1:0] sat_pos(input logic [PW-1:0] v);
        return (v == {PW{1'b1}}) ? v : v + PW'(1);
    endfunction

    function automatic logic [LW-1:0] sat_len(input logic [LW-1:0] v);
        return (v == {LW{1'b1}}) ? v : v + LW'(1);
    endfunction

    function automatic token_t mk(input logic [2:0] kind, input logic [PW-1:0] start,
                                  input logic [LW-1:0] len, input logic [PW-1:0] line);
        logic [PWX-1:0] ws;
        logic [PWX-1:0] wl;
        logic [LWX-1:0] wn;
        token_t t;
        ws = PWX'(start);
        wl = PWX'(line);
        wn = LWX'(len);
        t.kind   = kind;
        t.start  = ws[23:0];
        t.length = wn[15:0];
        t.line   = wl[23:0];
        return t;
    endfunction

    assign c = text_byte;

    always_comb
    begin
        st    = state_reg;
        pv    = prev_reg;
        ts    = tstart_reg;
        tl    = tline_reg;
        ln    = len_reg;
        go    = 1'b1;
        ended = 1'b0;
        n     = 2'd0;
        items = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (go)
            begin
                go = 1'b0;
                unique case (st)
                    S_SLASH:
                    begin
                        if (c == CH_SLASH)
                            st = S_LINE;
                        else if (c == CH_STAR)
                            st = S_BLOCK;
                        else
                        begin
                            st = S_IDLE;
                            if (c == CH_EQ)
                            begin
                                items[n] = mk(KIND_OP, ts, LW'(2), tl);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                items[n] = mk(KIND_OP, ts, LW'(1), tl);
                                n = n + 2'd1;
                                go = 1'b1;
                            end
                        end
                    end
                    S_LINE:
                    begin
                        if (c == CH_NUL)
                        begin
                            items[n] = mk(KIND_ERROR, pos_reg, LW'(0), line_reg);
                            n = n + 2'd1;
                            ended = 1'b1;
                        end
                        else if (c == CH_NL)
                            st = S_IDLE;
                    end
                    S_BLOCK:
                    begin
                        if (c == CH_NUL)
                        begin
                            items[n] = mk(KIND_ERROR, pos_reg, LW'(0), line_reg);
                            n = n + 2'd1;
                            ended = 1'b1;
                        end
                        else if (c == CH_STAR)
                            st = S_BSTAR;
                    end
                    S_BSTAR:
                    begin
                        if (c == CH_NUL)
                        begin
                            items[n] = mk(KIND_ERROR, pos_reg, LW'(0), line_reg);
                            n = n + 2'd1;
                            ended = 1'b1;
                        end
                        else if (c == CH_SLASH)
                            st = S_IDLE;
                        else if (c != CH_STAR)
                            st = S_BLOCK;
                    end
                    S_NAME:
                    begin
                        if (is_word(c))
                            ln = sat_len(ln);
                        else
                        begin
                            items[n] = mk(KIND_NAME, ts, ln, tl);
                            n = n + 2'd1;
                            st = S_IDLE;
                            go = 1'b1;
                        end
                    end
                    S_NUMBER:
                    begin
                        if (is_word(c) || (c == CH_DOT) ||
                            (((c == CH_PLUS) || (c == CH_MINUS)) &&
                             ((pv == CH_UP_E) || (pv == CH_LO_E))))
                        begin
                            ln = sat_len(ln);
                            pv = c;
                        end
                        else
                        begin
                            items[n] = mk(KIND_NUMBER, ts, ln, tl);
                            n = n + 2'd1;
                            st = S_IDLE;
                            go = 1'b1;
                        end
                    end
                    S_STRING:
                    begin
                        if (c == CH_NUL)
                        begin
                            items[n] = mk(KIND_ERROR, pos_reg, LW'(0), line_reg);
                            n = n + 2'd1;
                            ended = 1'b1;
                        end
                        else
                        begin
                            ln = sat_len(ln);
                            if (c == CH_QUOTE)
                            begin
                                items[n] = mk(KIND_STRING, ts, ln, tl);
                                n = n + 2'd1;
                                st = S_IDLE;
                            end
                        end
                    end
                    S_DOT:
                    begin
                        if (is_digit(c) || (c == CH_LO_F))
                        begin
                            st = S_NUMBER;
                            ln = LW'(2);
                            pv = c;
                        end
                        else if (c == CH_DOT)
                            st = S_DOTDOT;
                        else
                        begin
                            st = S_IDLE;
                            if (c == CH_STAR)
                            begin
                                items[n] = mk(KIND_OP, ts, LW'(2), tl);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                items[n] = mk(KIND_OP, ts, LW'(1), tl);
                                n = n + 2'd1;
                                go = 1'b1;
                            end
                        end
                    end
                    S_DOTDOT:
                    begin
                        if (c == CH_DOT)
                        begin
                            items[n] = mk(KIND_OP, ts, LW'(3), tl);
                            n = n + 2'd1;
                            st = S_IDLE;
                        end
                        else
                        begin
                            // The first dot stands alone; the second one starts afresh.
                            items[n] = mk(KIND_OP, ts, LW'(1), tl);
                            n = n + 2'd1;
                            ts = sat_pos(ts);
                            st = S_DOT;
                            go = 1'b1;
                        end
                    end
                    S_OP1:
                    begin
                        if ((pv == CH_MINUS) && (c == CH_GT))
                            st = S_ARROW;
                        else if (((pv == CH_LT) || (pv == CH_GT)) && (c == pv))
                            st = S_SHIFT;
                        else
                        begin
                            st = S_IDLE;
                            if (((c == pv) && pairs_self(pv)) || ((c == CH_EQ) && pairs_eq(pv)))
                            begin
                                items[n] = mk(KIND_OP, ts, LW'(2), tl);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                items[n] = mk(KIND_OP, ts, LW'(1), tl);
                                n = n + 2'd1;
                                go = 1'b1;
                            end
                        end
                    end
                    S_ARROW:
                    begin
                        st = S_IDLE;
                        if (c == CH_STAR)
                        begin
                            items[n] = mk(KIND_OP, ts, LW'(3), tl);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            items[n] = mk(KIND_OP, ts, LW'(2), tl);
                            n = n + 2'd1;
                            go = 1'b1;
                        end
                    end
                    S_SHIFT:
                    begin
                        st = S_IDLE;
                        if (c == CH_EQ)
                        begin
                            items[n] = mk(KIND_OP, ts, LW'(3), tl);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            items[n] = mk(KIND_OP, ts, LW'(2), tl);
                            n = n + 2'd1;
                            go = 1'b1;
                        end
                    end
                    default:
                    begin
                        st = S_IDLE;
                        if (c == CH_NUL)
                        begin
                            items[n] = mk(KIND_END, pos_reg, LW'(0), line_reg);
                            n = n + 2'd1;
                            ended = 1'b1;
                        end
                        else if (is_space(c))
                            st = S_IDLE;
                        else if ((c == CH_SLASH) || is_alpha(c) || (c == CH_UNDER) ||
                                 is_digit(c) || (c == CH_DOT) || (c == CH_QUOTE) ||
                                 (c == CH_LT) || (c == CH_GT) || pairs_self(c) || pairs_eq(c))
                        begin
                            ts = pos_reg;
                            tl = line_reg;
                            ln = LW'(1);
                            pv = c;
                            if (c == CH_SLASH)
                                st = S_SLASH;
                            else if (is_alpha(c) || (c == CH_UNDER))
                                st = S_NAME;
                            else if (is_digit(c))
                                st = S_NUMBER;
                            else if (c == CH_DOT)
                                st = S_DOT;
                            else if (c == CH_QUOTE)
                                st = S_STRING;
                            else
                                st = S_OP1;
                        end
                        else
                        begin
                            items[n] = mk(KIND_OP, pos_reg, LW'(1), line_reg);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
        end

        if (ended)
        begin
            state_next  = S_IDLE;
            prev_next   = 8'h00;
            tstart_next = '0;
            tline_next  = PW'(1);
            pos_next    = '0;
            line_next   = PW'(1);
            len_next    = '0;
        end
        else
        begin
            state_next  = st;
            prev_next   = pv;
            tstart_next = ts;
            tline_next  = tl;
            pos_next    = sat_pos(pos_reg);
            line_next   = (c == CH_NL) ? sat_pos(line_reg) : line_reg;
            len_next    = ln;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prev_reg   <= 8'h00;
            tstart_reg <= '0;
            tline_reg  <= PW'(1);
            pos_reg    <= '0;
            line_reg   <= PW'(1);
            len_reg    <= '0;
        end
        else if (accept)
        begin
            state_reg  <= state_next;
            prev_reg   <= prev_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            len_reg    <= len_next;
        end
    end

    assign push.count = accept ? n : 2'd0;
    assign push.item  = items;

endmodule

FILE: sv/c_like_token_lexer_top.sv
// Tokens that an accepted text word yields are written into the token queue as that word is accepted.
// Throughput: one text word per cycle while the token queue holds at most one word; a word
// that yields two or three tokens pushes all of them into the four-entry token queue at once.
// Input is taken whenever the token queue holds at most one word, so ready follows the count.
// Reset is asynchronous and active low; it returns the lexer to the start of a text.
module c_like_token_lexer_top
    import cltl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    cltl_byte_if.sink           text_in,
    cltl_token_if.source        token_out
);

    typedef struct packed {
        token_t tok;
        logic   last;
    } entry_t;

    entry_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  accept;
    logic                  pop;
    push_t                 push;
    entry_t                head;

    assign text_in.ready = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - MAX_RESULTS));
    assign accept        = text_in.valid && text_in.ready;
    assign pop           = token_out.valid && token_out.ready;

    cltl_core #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_in.text_byte),
        .push      (push)
    );

    assign wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
    assign count_next  = count_reg + QUEUE_CW'(push.count) - QUEUE_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push.count)
            begin
                mem[wr_ptr_reg + QUEUE_AW'(k)] <= '{push.item[k], (2'(k) == push.count - 2'd1)};
            end
        end
    end

    assign head = mem[rd_ptr_reg];

    assign token_out.valid          = (count_reg != '0);
    assign token_out.token_kind     = head.tok.kind;
    assign token_out.start_position = head.tok.start;
    assign token_out.token_length   = head.tok.length;
    assign token_out.line_number    = head.tok.line;
    assign token_out.last_of_run    = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("token queue holds more words than it has entries");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> accept)
        else $error("tokens pushed without an accepted text word");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (token_out.valid &&
         ((token_out.token_kind == KIND_END) || (token_out.token_kind == KIND_ERROR)))
        |-> (token_out.last_of_run && (token_out.token_length == 16'd0)))
        else $error("end token is not the final zero-length word of its run");

endmodule
